### src/sfcd_pkg.sv
// Package for the sensor frame CRC decoder: frame positions, CRC and
// temperature conversion constants, the frame result struct and the CRC-8 step.
// No dependencies.
`default_nettype none

package sfcd_pkg;

	localparam int POS_W = 3;
	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int TEMP_W = 12;
	localparam int QUOT_W = 11;
	localparam int PROD_W = WORD_W + QUOT_W;

	// byte positions in a frame
	localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
	localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
	localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
	localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	localparam logic [QUOT_W-1:0]        T_SPAN   = 11'd1750;
	localparam logic [WORD_W:0]          T_FULL   = 17'd65535;
	localparam logic signed [TEMP_W-1:0] T_OFFSET = 12'sd450;
	localparam logic signed [TEMP_W-1:0] T_MIN    = -12'sd450;
	localparam logic signed [TEMP_W-1:0] T_MAX    = 12'sd1300;

	typedef struct packed {
		logic              last;   // byte completes the frame
		logic              bad;    // either CRC mismatched
		logic [WORD_W-1:0] humid;
	} frame_res_t;

	// CRC-8, MSB first, one byte
	function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### src/sensor_frame_crc_decode.sv
// Sensor readout frame decoder: input register, frame tracker, result register.
// A frame's last byte passes the input register, then the result register, before its result is offered.
// Throughput: one byte per cycle; only a stalled result whose successor is
// the last byte of the next frame holds the input.
// Reset: asynchronous, active low; clears position, CRC status and valid flags.
// Depends on sfcd_pkg, sfcd_frame, sfcd_temp.
`default_nettype none

module sensor_frame_crc_decode import sfcd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [BYTE_W-1:0]        rx_byte,
	input  wire logic                     frame_start,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          status,
	output logic signed [TEMP_W-1:0]      temperature_tenths,
	output logic [WORD_W-1:0]             humidity_raw
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	logic                     out_valid_q;
	logic                     status_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [WORD_W-1:0]        humid_q;

	frame_res_t               fres;
	logic [WORD_W-1:0]        temp_word;
	logic signed [TEMP_W-1:0] tenths;
	logic                     step;

	assign in_stall = valid_s1 && fres.last && out_valid_q && out_stall;
	assign step     = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	sfcd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.start_in  (start_s1),
		.res       (fres),
		.temp_word (temp_word)
	);

	sfcd_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.temp_word (temp_word),
		.tenths    (tenths)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && fres.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fres.last) begin
			status_q <= fres.bad;
			temp_q   <= fres.bad ? '0 : tenths;
			humid_q  <= fres.humid;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign temperature_tenths = temp_q;
	assign humidity_raw       = humid_q;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && fres.last))
		else $error("input held without a blocked result");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (temperature_tenths == '0))
		else $error("temperature not zero on checksum error");
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |->
		(temperature_tenths >= T_MIN && temperature_tenths <= T_MAX))
		else $error("temperature out of range");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step && fres.last))
		else $error("result without a final frame byte");
`endif

endmodule

`default_nettype wire

### src/sfcd_frame.sv
// Frame tracker: byte position, running CRC, received words and CRC status.
// Depends on sfcd_pkg.
`default_nettype none

module sfcd_frame import sfcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic              start_in,
	output frame_res_t             res,
	output logic [WORD_W-1:0]      temp_word
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [WORD_W-1:0] temp_word_q;
	logic [WORD_W-1:0] humid_word_q;
	logic              failed_q;

	logic [POS_W-1:0]  pos_eff;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_upd;
	logic              mismatch;

	always_comb begin
		if (start_in || pos_q > POS_H_CRC) begin
			pos_eff = POS_T_HI;
		end else begin
			pos_eff = pos_q;
		end
		crc_base = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_q;
		crc_upd  = crc_byte(crc_base, byte_in);
		mismatch = byte_in != crc_q;
	end

	assign res.last  = pos_eff == POS_H_CRC;
	assign res.bad   = failed_q || mismatch;
	assign res.humid = humid_word_q;
	assign temp_word = temp_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_T_HI;
			crc_q        <= CRC_INIT;
			temp_word_q  <= '0;
			humid_word_q <= '0;
			failed_q     <= 1'b0;
		end else if (step) begin
			pos_q <= (pos_eff == POS_H_CRC) ? POS_T_HI : pos_eff + 3'd1;
			case (pos_eff)
				POS_T_HI: begin
					crc_q       <= crc_upd;
					temp_word_q <= {byte_in, 8'h00};
				end
				POS_T_LO: begin
					crc_q       <= crc_upd;
					temp_word_q <= {temp_word_q[WORD_W-1:BYTE_W], byte_in};
				end
				POS_T_CRC: begin
					failed_q <= mismatch;
				end
				POS_H_HI: begin
					crc_q        <= crc_upd;
					humid_word_q <= {byte_in, 8'h00};
				end
				POS_H_LO: begin
					crc_q        <= crc_upd;
					humid_word_q <= {humid_word_q[WORD_W-1:BYTE_W], byte_in};
				end
				default: begin
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_H_CRC)
		else $error("frame position out of range");
`endif

endmodule

`default_nettype wire

### src/sfcd_temp.sv
// Temperature conversion: floor(word * 1750 / 65535) - 450 in tenths of a degree.
// Product registered, then divide by 65535 with one correction step. Depends on sfcd_pkg.
`default_nettype none

module sfcd_temp import sfcd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [WORD_W-1:0]        temp_word,
	output logic signed [TEMP_W-1:0]      tenths
);

	logic [PROD_W-1:0] prod_q;
	logic [QUOT_W-1:0] q0;
	logic [WORD_W:0]   r0;
	logic [QUOT_W-1:0] quot;

	// word is stable for several transfers before the last byte arrives
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(temp_word) * PROD_W'(T_SPAN);
	end

	// x = q0*65536 + lo = q0*65535 + (lo + q0); remainder stays below 2*65535
	always_comb begin
		q0     = prod_q[PROD_W-1:WORD_W];
		r0     = {1'b0, prod_q[WORD_W-1:0]} + (WORD_W+1)'(q0);
		quot   = (r0 >= T_FULL) ? q0 + 11'd1 : q0;
		tenths = signed'({1'b0, quot}) - T_OFFSET;
	end

`ifndef NO_ASSERTIONS
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		quot <= T_SPAN)
		else $error("temperature quotient above span");
`endif

endmodule

`default_nettype wire
